// File: hdl/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants for the RGB percent chromaticity block
// Pixel and result word layouts, percent scale and the reciprocal used for
// the divide by three.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

	localparam int unsigned ChanW  = 8;
	localparam int unsigned ShareW = 7;
	localparam int unsigned SumW   = 10;   // 3 * 255 fits in 10 bits
	localparam int unsigned NumW   = 15;   // 255 * 100 fits in 15 bits

	localparam logic [6:0] PctScale = 7'd100;

	// floor(s / 3) == (s * 683) >> 11 for every s in 0..765
	localparam logic [9:0] GrayRecip = 10'd683;
	localparam int unsigned GrayShift = 11;
	localparam int unsigned GrayProdW = 2 * SumW;

	typedef struct packed {
		logic [ChanW-1:0] red_in;
		logic [ChanW-1:0] green_in;
		logic [ChanW-1:0] blue_in;
		logic             row_end_in;
		logic             frame_end_in;
	} pixel_t;

	typedef struct packed {
		logic [ChanW-1:0]  gray_out;
		logic [ShareW-1:0] red_share;
		logic [ShareW-1:0] green_share;
		logic [ShareW-1:0] blue_share;
		logic              row_end_out;
		logic              frame_end_out;
	} result_t;

endpackage

`default_nettype wire

// File: hdl/rpc_share_div.sv
// ----------------------------------------------------------------------------
// rpc_share_div: pipelined restoring divider for one channel share
// Divides a scaled channel (channel * 100) by the channel sum. The quotient
// never exceeds 100, so seven quotient bits are resolved, two per stage and one in the last.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_share_div (
	input  wire logic                       clk,
	input  wire logic [rpc_pkg::NumW-1:0]   num,
	input  wire logic [rpc_pkg::SumW-1:0]   den,
	output logic      [rpc_pkg::ShareW-1:0] quot
);
	import rpc_pkg::*;

	// One restoring step: returns {quotient bit, new remainder}
	function automatic logic [NumW:0] div_bit(
		input logic [NumW-1:0] rem,
		input logic [SumW-1:0] dv,
		input logic [2:0]      k
	);
		logic [NumW+1:0] dsh;
		logic [NumW+1:0] diff;
		dsh  = (NumW+2)'(dv) << k;
		diff = {2'b00, rem} - dsh;
		if ({2'b00, rem} >= dsh) begin
			return {1'b1, diff[NumW-1:0]};
		end
		return {1'b0, rem};
	endfunction

	logic [NumW-1:0]   rem_s2, rem_s3, rem_s4;
	logic [SumW-1:0]   den_s2, den_s3, den_s4;
	logic [ShareW-1:0] q_s2, q_s3, q_s4, q_s5;

	logic [NumW:0] b6, b5, b4, b3, b2, b1, b0;

	always_comb begin
		b6 = div_bit(num, den, 3'd6);
		b5 = div_bit(b6[NumW-1:0], den, 3'd5);
		b4 = div_bit(rem_s2, den_s2, 3'd4);
		b3 = div_bit(b4[NumW-1:0], den_s2, 3'd3);
		b2 = div_bit(rem_s3, den_s3, 3'd2);
		b1 = div_bit(b2[NumW-1:0], den_s3, 3'd1);
		b0 = div_bit(rem_s4, den_s4, 3'd0);
	end

	always_ff @(posedge clk) begin
		rem_s2 <= b5[NumW-1:0];
		den_s2 <= den;
		q_s2   <= {b6[NumW], b5[NumW], 5'b0};

		rem_s3 <= b3[NumW-1:0];
		den_s3 <= den_s2;
		q_s3   <= {q_s2[6:5], b4[NumW], b3[NumW], 3'b0};

		rem_s4 <= b1[NumW-1:0];
		den_s4 <= den_s3;
		q_s4   <= {q_s3[6:3], b2[NumW], b1[NumW], 1'b0};

		q_s5   <= {q_s4[6:1], b0[NumW]};
	end

	assign quot = q_s5;

endmodule

`default_nettype wire

// File: hdl/rgb_percent_chromaticity.sv
// ----------------------------------------------------------------------------
// rgb_percent_chromaticity: gray level and per-channel percent shares
// valid_s1 to valid_s5 carry start to done; throughput one pixel every cycle.
// The four-stage share divider sets the latency; busy is always low.
// Results appear on done for one cycle and cannot be held off.
// Reset clears only the valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_percent_chromaticity (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire rpc_pkg::pixel_t   pixel,
	output logic                   done,
	output rpc_pkg::result_t       result
);
	import rpc_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic [SumW-1:0]      sum_c;
	logic [SumW-1:0]      sum_s1;
	logic [NumW-1:0]      red_num_s1, green_num_s1, blue_num_s1;
	logic [GrayProdW-1:0] gray_prod_s2;
	logic [ChanW-1:0]     gray_s3, gray_s4, gray_s5;
	logic [1:0]           marks_s1, marks_s2, marks_s3, marks_s4, marks_s5;
	logic [ShareW-1:0]    red_q, green_q, blue_q;

	assign busy = 1'b0;

	always_comb begin
		sum_c = SumW'(pixel.red_in) + SumW'(pixel.green_in) + SumW'(pixel.blue_in);
		// black pixel: divide by one
		if (sum_c == '0) begin
			sum_c = SumW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		sum_s1       <= sum_c;
		red_num_s1   <= NumW'(pixel.red_in) * NumW'(PctScale);
		green_num_s1 <= NumW'(pixel.green_in) * NumW'(PctScale);
		blue_num_s1  <= NumW'(pixel.blue_in) * NumW'(PctScale);
		marks_s1     <= {pixel.row_end_in, pixel.frame_end_in};

		gray_prod_s2 <= GrayProdW'(sum_s1) * GrayProdW'(GrayRecip);
		marks_s2     <= marks_s1;

		gray_s3      <= ChanW'(gray_prod_s2 >> GrayShift);
		marks_s3     <= marks_s2;

		gray_s4      <= gray_s3;
		marks_s4     <= marks_s3;

		gray_s5      <= gray_s4;
		marks_s5     <= marks_s4;
	end

	rpc_share_div u_red_div (
		.clk  (clk),
		.num  (red_num_s1),
		.den  (sum_s1),
		.quot (red_q)
	);

	rpc_share_div u_green_div (
		.clk  (clk),
		.num  (green_num_s1),
		.den  (sum_s1),
		.quot (green_q)
	);

	rpc_share_div u_blue_div (
		.clk  (clk),
		.num  (blue_num_s1),
		.den  (sum_s1),
		.quot (blue_q)
	);

	assign done                 = valid_s5;
	assign result.gray_out      = gray_s5;
	assign result.red_share     = red_q;
	assign result.green_share   = green_q;
	assign result.blue_share    = blue_q;
	assign result.row_end_out   = marks_s5[1];
	assign result.frame_end_out = marks_s5[0];

	// every accepted word comes out on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##5 done)
		else $error("accepted word did not complete after five cycles");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 5))
		else $error("result strobe without an accepted word");

	a_share_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.red_share <= ShareW'(PctScale)
			&& result.green_share <= ShareW'(PctScale)
			&& result.blue_share <= ShareW'(PctScale)))
		else $error("channel share above one hundred");

	a_share_total: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((9'(result.red_share) + 9'(result.green_share)
			+ 9'(result.blue_share)) <= 9'(PctScale)))
		else $error("channel shares add up to more than one hundred");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RGB percent chromaticity block
// Drives pixels with random gaps, predicts gray level and per-channel
// percent shares for every accepted word, and checks each done word in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	import rpc_pkg::*;

	localparam int unsigned PercentScale = 100;
	localparam int unsigned GrayDivisor  = 3;
	localparam int unsigned RandomPixels = 1800;
	localparam int unsigned IdlePercent  = 21;
	localparam int unsigned DrainCycles  = 12;
	localparam int unsigned CycleLimit   = 200000;
	localparam int unsigned MaxReports   = 40;
	localparam int unsigned PixelW       = $bits(pixel_t);

	class chroma_scoreboard;
		result_t     due_results[$];
		int unsigned errors;
		int unsigned checked;

		function new();
			errors  = 0;
			checked = 0;
		endfunction

		function result_t chroma_of(pixel_t p);
			int unsigned total;
			result_t     r;
			total = int'(p.red_in) + int'(p.green_in) + int'(p.blue_in);
			// black pixel divides by one
			if (total == 0) begin
				total = 1;
			end
			r.gray_out      = ChanW'(total / GrayDivisor);
			r.red_share     = ShareW'((int'(p.red_in) * PercentScale) / total);
			r.green_share   = ShareW'((int'(p.green_in) * PercentScale) / total);
			r.blue_share    = ShareW'((int'(p.blue_in) * PercentScale) / total);
			r.row_end_out   = p.row_end_in;
			r.frame_end_out = p.frame_end_in;
			return r;
		endfunction

		function void note_pixel(pixel_t p);
			due_results.push_back(chroma_of(p));
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				if (errors <= MaxReports) begin
					$display("[%0t] mismatch on %s: expected %0d, actual %0d",
						$time, field, want, got);
				end
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= MaxReports) begin
					$display("[%0t] unexpected word: expected none, actual %h", $time, got);
				end
				return;
			end
			want = due_results.pop_front();
			checked++;
			compare_field("gray_out", 32'(want.gray_out), 32'(got.gray_out));
			compare_field("red_share", 32'(want.red_share), 32'(got.red_share));
			compare_field("green_share", 32'(want.green_share), 32'(got.green_share));
			compare_field("blue_share", 32'(want.blue_share), 32'(got.blue_share));
			compare_field("row_end_out", 32'(want.row_end_out), 32'(got.row_end_out));
			compare_field("frame_end_out", 32'(want.frame_end_out),
				32'(got.frame_end_out));
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	pixel_t  pixel;
	logic    done;
	result_t result;

	chroma_scoreboard sb;
	int unsigned      sent_pixels;
	int unsigned      black_pixels;
	int unsigned      frames_sent;
	int unsigned      cycle_count;
	bit               idle_enable;

	rgb_percent_chromaticity dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pixel  (pixel),
		.done   (done),
		.result (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// sample both handshakes at the edge that accepts them
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			sb.note_pixel(pixel);
		end
		if (arst_n && done) begin
			sb.check_result(result);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	function logic [ChanW-1:0] pick_channel();
		case ($urandom_range(9))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			2: begin
				return ChanW'($urandom_range(3));
			end
			3: begin
				return ChanW'(8'd255 - $urandom_range(3));
			end
			default: begin
				return ChanW'($urandom);
			end
		endcase
	endfunction

	function pixel_t make_pixel(logic row_end, logic frame_end);
		pixel_t p;
		p.red_in       = pick_channel();
		p.green_in     = pick_channel();
		p.blue_in      = pick_channel();
		p.row_end_in   = row_end;
		p.frame_end_in = frame_end;
		return p;
	endfunction

	function pixel_t fixed_pixel(int unsigned r, int unsigned g, int unsigned b,
			logic row_end, logic frame_end);
		pixel_t p;
		p.red_in       = ChanW'(r);
		p.green_in     = ChanW'(g);
		p.blue_in      = ChanW'(b);
		p.row_end_in   = row_end;
		p.frame_end_in = frame_end;
		return p;
	endfunction

	task automatic send_pixel(input pixel_t p);
		// idle with junk on the bus so the block must ignore it
		while (idle_enable && ($urandom_range(99) < IdlePercent)) begin
			start <= 1'b0;
			pixel <= pixel_t'(PixelW'($urandom));
			@(posedge clk);
		end
		pixel <= p;
		start <= 1'b1;
		do begin
			@(posedge clk);
		end while (busy);
		sent_pixels++;
		if (p.red_in == 0 && p.green_in == 0 && p.blue_in == 0) begin
			black_pixels++;
		end
		if (p.frame_end_in) begin
			frames_sent++;
		end
	endtask

	task automatic send_directed();
		send_pixel(fixed_pixel(0, 0, 0, 1'b0, 1'b0));
		send_pixel(fixed_pixel(255, 255, 255, 1'b0, 1'b0));
		send_pixel(fixed_pixel(255, 0, 0, 1'b1, 1'b0));
		send_pixel(fixed_pixel(0, 255, 0, 1'b0, 1'b1));
		send_pixel(fixed_pixel(0, 0, 255, 1'b1, 1'b1));
		send_pixel(fixed_pixel(1, 0, 0, 1'b0, 1'b0));
		send_pixel(fixed_pixel(0, 1, 0, 1'b0, 1'b0));
		send_pixel(fixed_pixel(0, 0, 1, 1'b0, 1'b0));
		// shares that truncate to a total below 100
		send_pixel(fixed_pixel(1, 1, 1, 1'b0, 1'b0));
		send_pixel(fixed_pixel(85, 85, 85, 1'b0, 1'b0));
		send_pixel(fixed_pixel(1, 2, 3, 1'b1, 1'b0));
		send_pixel(fixed_pixel(255, 255, 254, 1'b0, 1'b0));
		send_pixel(fixed_pixel(254, 1, 0, 1'b0, 1'b0));
		send_pixel(fixed_pixel(0, 0, 0, 1'b1, 1'b1));
		send_pixel(fixed_pixel(0, 0, 0, 1'b1, 1'b0));
		send_pixel(fixed_pixel(0, 0, 0, 1'b0, 1'b1));
		send_pixel(fixed_pixel(170, 85, 0, 1'b0, 1'b0));
		send_pixel(fixed_pixel(255, 1, 1, 1'b0, 1'b0));
		send_pixel(fixed_pixel(1, 255, 255, 1'b1, 1'b1));
		send_pixel(fixed_pixel(2, 0, 1, 1'b0, 1'b0));
	endtask

	task automatic send_random();
		int unsigned row_len;
		int unsigned rows;
		int unsigned base;
		logic        row_end;
		logic        frame_end;
		base = sent_pixels;
		while (sent_pixels - base < RandomPixels) begin
			// hold a long stretch with no gaps in the middle of the run
			idle_enable = !((sent_pixels - base > 600) && (sent_pixels - base < 1000));
			if ($urandom_range(9) == 0) begin
				send_pixel(make_pixel(1'($urandom_range(1)), 1'($urandom_range(1))));
			end else begin
				row_len = $urandom_range(1, 12);
				rows    = $urandom_range(1, 6);
				for (int unsigned y = 0; y < rows; y++) begin
					for (int unsigned x = 0; x < row_len; x++) begin
						row_end   = (x == row_len - 1);
						frame_end = row_end && (y == rows - 1);
						send_pixel(make_pixel(row_end, frame_end));
					end
				end
			end
		end
	endtask

	initial begin
		sb           = new();
		sent_pixels  = 0;
		black_pixels = 0;
		frames_sent  = 0;
		cycle_count  = 0;
		idle_enable  = 1'b1;
		arst_n <= 1'b0;
		start  <= 1'b0;
		pixel  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_directed();
		send_random();
		start <= 1'b0;

		// drain, then watch for stray words
		while (sb.due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);

		$display("covered %0d pixels (%0d black) in %0d frames, %0d words checked",
			sent_pixels, black_pixels, frames_sent, sb.checked);
		if (sb.errors == 0 && sb.due_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: rgb_percent_chromaticity.f
hdl/rpc_pkg.sv
hdl/rpc_share_div.sv
hdl/rgb_percent_chromaticity.sv
tb/sv/tb_top.sv
